/* design/rif_pkg.sv */
// Package for the radix integer formatter: field widths, ASCII codes,
// the digit-to-character function and the controller/datapath link types.
// Used by every module of the block; depends on nothing.
package rif_pkg;

    localparam int VALUE_W            = 64;
    localparam int RADIX_W            = 6;
    localparam int CHAR_W             = 7;
    localparam int VALUE_BITS_DEFAULT = 64;
    // Quotient bits produced per divider cycle.
    localparam int BITS_PER_CYCLE     = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
    localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic emit_sign;
        logic emit_digit;
    } rif_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic step_done;
        logic quot_zero;
        logic negative;
        logic last_digit;
        logic out_free;
    } rif_sts_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_DIGITS)
            c = CHAR_ZERO + CHAR_W'(d);
        else
            c = CHAR_A + CHAR_W'(d - DEC_DIGITS);
        return c;
    endfunction

endpackage

/* design/rif_if.sv */
// Valid/ready channel interfaces of the radix integer formatter:
// the request channel (value, radix) and the character channel (character, last).
// Depends on rif_pkg.
interface rif_in_if;
    logic                          valid;
    logic                          ready;
    logic [rif_pkg::VALUE_W-1:0]   value;
    logic [rif_pkg::RADIX_W-1:0]   radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

interface rif_out_if;
    logic                          valid;
    logic                          ready;
    logic [rif_pkg::CHAR_W-1:0]    character;
    logic                          last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

/* design/rif_ctrl.sv */
// Controller of the radix integer formatter: sequences load, digit
// division, sign output and digit output.
// Depends on rif_pkg.
module rif_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rif_pkg::rif_sts_t sts,
    output rif_pkg::rif_cmd_t cmd
);
    import rif_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.step = 1'b1;
                if (sts.step_done && sts.quot_zero)
                    state_next = sts.negative ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (sts.last_digit)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* design/rif_dp.sv */
// Datapath of the radix integer formatter: magnitude and radix capture,
// multi-bit restoring divider, digit stack and character output register.
// Depends on rif_pkg.
module rif_dp #(
    parameter int VALUE_BITS = rif_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [rif_pkg::VALUE_W-1:0] value,
    input  logic [rif_pkg::RADIX_W-1:0] radix,
    input  rif_pkg::rif_cmd_t           cmd,
    output rif_pkg::rif_sts_t           sts,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [rif_pkg::CHAR_W-1:0]  character,
    output logic                        last
);
    import rif_pkg::*;

    localparam int MAG_BITS = VALUE_BITS - 1;
    localparam int STEPS    = (MAG_BITS + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
    localparam int DIV_BITS = STEPS * BITS_PER_CYCLE;
    localparam int STEP_W   = $clog2(STEPS + 1);
    localparam int CNT_W    = $clog2(MAG_BITS + 1);
    localparam int PTR_W    = $clog2(MAG_BITS);

    logic [DIV_BITS-1:0]       div_reg;
    logic [RADIX_W-1:0]        rem_reg;
    logic [RADIX_W-1:0]        radix_reg;
    logic                      negative_reg;
    logic [STEP_W-1:0]         step_cnt_reg;
    logic [CNT_W-1:0]          dcnt_reg;
    logic [RADIX_W-1:0]        digit_mem [MAG_BITS];
    logic [RADIX_W-1:0]        top_reg;
    logic                      out_valid_reg;
    logic [CHAR_W-1:0]         char_reg;
    logic                      last_reg;

    logic [MAG_BITS-1:0]       low;
    logic [MAG_BITS-1:0]       mag;
    logic                      sign_in;
    logic [RADIX_W-1:0]        radix_sat;
    logic [BITS_PER_CYCLE-1:0] qbits;
    logic [RADIX_W-1:0]        rem_next;
    logic [DIV_BITS-1:0]       quot_next;
    logic                      step_done;
    logic [CNT_W-1:0]          pop_addr;

    // Magnitude: the most negative value clamps to the largest positive one.
    assign sign_in = value[VALUE_BITS-1];
    assign low     = value[MAG_BITS-1:0];

    always_comb
    begin
        if (!sign_in)
            mag = low;
        else if (low == '0)
            mag = '1;
        else
            mag = '0 - low;
    end

    always_comb
    begin
        if (radix < RADIX_MIN)
            radix_sat = RADIX_MIN;
        else if (radix > RADIX_MAX)
            radix_sat = RADIX_MAX;
        else
            radix_sat = radix;
    end

    // Restoring division, BITS_PER_CYCLE quotient bits per cycle.
    always_comb
    begin
        logic [RADIX_W:0]   trial;
        logic [RADIX_W-1:0] r;
        r     = rem_reg;
        qbits = '0;
        for (int i = 0; i < BITS_PER_CYCLE; i++)
        begin
            trial = {r, div_reg[DIV_BITS-1-i]};
            if (trial >= {1'b0, radix_reg})
            begin
                trial                      = trial - {1'b0, radix_reg};
                qbits[BITS_PER_CYCLE-1-i] = 1'b1;
            end
            r = trial[RADIX_W-1:0];
        end
        rem_next  = r;
        quot_next = (div_reg << BITS_PER_CYCLE) | DIV_BITS'(qbits);
    end

    assign step_done = (step_cnt_reg == STEP_W'(STEPS - 1));

    // Entry just below the current top, valid while two or more digits are held.
    assign pop_addr = dcnt_reg - CNT_W'(2);

    assign sts.step_done  = step_done;
    assign sts.quot_zero  = (quot_next == '0);
    assign sts.negative   = negative_reg;
    assign sts.last_digit = (dcnt_reg == CNT_W'(1));
    assign sts.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            radix_reg     <= RADIX_MIN;
            negative_reg  <= 1'b0;
            step_cnt_reg  <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                rem_reg      <= '0;
                radix_reg    <= radix_sat;
                negative_reg <= sign_in;
                step_cnt_reg <= '0;
                dcnt_reg     <= '0;
            end
            else if (cmd.step)
            begin
                if (step_done)
                begin
                    rem_reg      <= '0;
                    step_cnt_reg <= '0;
                    dcnt_reg     <= dcnt_reg + CNT_W'(1);
                end
                else
                begin
                    rem_reg      <= rem_next;
                    step_cnt_reg <= step_cnt_reg + STEP_W'(1);
                end
            end
            else if (cmd.emit_digit)
            begin
                dcnt_reg <= dcnt_reg - CNT_W'(1);
            end

            if (cmd.emit_sign || cmd.emit_digit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload: dividend/quotient, digit stack, output character.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            div_reg <= DIV_BITS'(mag);
        else if (cmd.step)
            div_reg <= quot_next;

        // Push writes at the fill count and copies the digit into top_reg;
        // pop reloads top_reg from the entry below it.
        if (cmd.step && step_done)
        begin
            digit_mem[dcnt_reg[PTR_W-1:0]] <= rem_next;
            top_reg                        <= rem_next;
        end
        else if (cmd.emit_digit && (dcnt_reg > CNT_W'(1)))
        begin
            top_reg <= digit_mem[pop_addr[PTR_W-1:0]];
        end

        if (cmd.emit_sign)
        begin
            char_reg <= CHAR_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= digit_char(top_reg);
            last_reg <= (dcnt_reg == CNT_W'(1));
        end
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg < radix_reg)
        else $error("remainder not below radix");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_sign || cmd.emit_digit) |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten while stalled");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_digit |-> (dcnt_reg != '0))
        else $error("digit popped from empty stack");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && step_done) |-> (dcnt_reg < CNT_W'(MAG_BITS)))
        else $error("digit stack overflow");

    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_digit && dcnt_reg == CNT_W'(1)) |=> (dcnt_reg == '0))
        else $error("digit count not empty after last character");
`endif

endmodule

/* design/radix_integer_formatter_core.sv */
// Top level of the radix integer formatter: controller plus datapath,
// request and character channels. Depends on rif_pkg, rif_if, rif_ctrl, rif_dp.
//
// Formats one signed VALUE_BITS-bit integer (low bits of the 64-bit value
// field) in a radix from 2 to 36 (out-of-range radix saturates) and sends
// its text one ASCII character per transfer on the character channel, most
// significant first: a '-' for negative values, then digits 0-9 and A-Z,
// with last set on the final character. Zero gives a single '0', and the
// most negative value is printed as the largest positive magnitude with a
// minus sign. One request is handled at a time: the request channel is
// ready only while the block is idle, which it reaches as soon as the final
// character sits in the output register. A request is loaded, then each digit
// is produced by the restoring divider (eight quotient bits per cycle) and
// pushed on the digit stack, then the characters are sent one per cycle while
// the sink keeps ready high. The divider is the bottleneck.
module radix_integer_formatter_core #(
    parameter int VALUE_BITS = rif_pkg::VALUE_BITS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    rif_in_if.sink    req,
    rif_out_if.source chars
);
    import rif_pkg::*;

    rif_cmd_t cmd;
    rif_sts_t sts;

    // Sequence load, divide, sign and digit output.
    rif_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold magnitude, divide, stack digits, drive the output register.
    rif_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (req.value),
        .radix     (req.radix),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (chars.ready),
        .out_valid (chars.valid),
        .character (chars.character),
        .last      (chars.last)
    );

`ifndef SYNTHESIS
    a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load == (req.valid && req.ready))
        else $error("load command does not match request acceptance");

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step || cmd.emit_sign || cmd.emit_digit) |-> !req.ready)
        else $error("request channel ready while busy");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_sign || cmd.emit_digit) |=> chars.valid)
        else $error("character not presented after emit");
`endif

endmodule
